>>> hw/rtl/mcft_pkg.sv
// ----------------------------------------------------------------------------
// mcft_pkg
// Shared types, codes, constants and the control store of the frame timer.
// ----------------------------------------------------------------------------
package mcft_pkg;

  // Command codes carried by an input word.
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_TRIG = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  // Status codes carried by a result word.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOALLOC = 2'd2;

  // Field widths.
  localparam int ID_W      = 5;
  localparam int CNT_OUT_W = 6;
  localparam int FRAME_W   = 24;
  localparam int RATE_W    = 16;
  localparam int DELTA_W   = 16;
  localparam int D30_W     = 21;
  localparam int PROD_W    = RATE_W + D30_W;
  localparam int STEP_LSB  = 16;
  localparam int CFG_W     = 1 + RATE_W + FRAME_W;

  // Defaults: 100.0 frames in Q16.8, rate 1.0 in Q8.8, and frames per second.
  localparam logic [FRAME_W-1:0] DEFAULT_LENGTH = 24'd25600;
  localparam logic [RATE_W-1:0]  DEFAULT_RATE   = 16'd256;
  localparam logic [D30_W-1:0]   FRAMES_PER_SEC = 21'd30;

  // Control store addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] U_ADD    = 4'd1;
  localparam logic [UPC_W-1:0] U_TICK   = 4'd2;
  localparam logic [UPC_W-1:0] U_TREAD  = 4'd3;
  localparam logic [UPC_W-1:0] U_TMUL   = 4'd4;
  localparam logic [UPC_W-1:0] U_TUPD   = 4'd5;
  localparam logic [UPC_W-1:0] U_TRIG   = 4'd6;
  localparam logic [UPC_W-1:0] U_RISSUE = 4'd7;
  localparam logic [UPC_W-1:0] U_RCAP   = 4'd8;
  localparam logic [UPC_W-1:0] U_EMIT   = 4'd9;

  // Datapath operations.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_ADD       = 4'd1;
  localparam logic [3:0] OP_TICK_INIT = 4'd2;
  localparam logic [3:0] OP_CH_READ   = 4'd3;
  localparam logic [3:0] OP_MUL       = 4'd4;
  localparam logic [3:0] OP_UPD       = 4'd5;
  localparam logic [3:0] OP_TRIG      = 4'd6;
  localparam logic [3:0] OP_RD_ISSUE  = 4'd7;
  localparam logic [3:0] OP_RD_CAP    = 4'd8;
  localparam logic [3:0] OP_EMIT      = 4'd9;

  // Jump conditions.
  localparam logic [2:0] C_NEXT      = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_ACCEPT    = 3'd2;
  localparam logic [2:0] C_ITER_DONE = 3'd3;
  localparam logic [2:0] C_OUT_FREE  = 3'd4;

  // One control word: operation, jump condition, hold when false, target.
  typedef struct packed {
    logic [3:0]       op;
    logic [2:0]       cond;
    logic             hold;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       idle;
    logic [3:0] op;
  } seq_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic iter_done;
    logic out_free;
  } dp_flags_t;

  // The microprogram.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      U_IDLE:   w = '{op: OP_NONE,      cond: C_ACCEPT,    hold: 1'b1, target: U_IDLE};
      U_ADD:    w = '{op: OP_ADD,       cond: C_ALWAYS,    hold: 1'b0, target: U_EMIT};
      U_TICK:   w = '{op: OP_TICK_INIT, cond: C_NEXT,      hold: 1'b0, target: U_IDLE};
      U_TREAD:  w = '{op: OP_CH_READ,   cond: C_ITER_DONE, hold: 1'b0, target: U_EMIT};
      U_TMUL:   w = '{op: OP_MUL,       cond: C_NEXT,      hold: 1'b0, target: U_IDLE};
      U_TUPD:   w = '{op: OP_UPD,       cond: C_ALWAYS,    hold: 1'b0, target: U_TREAD};
      U_TRIG:   w = '{op: OP_TRIG,      cond: C_ALWAYS,    hold: 1'b0, target: U_EMIT};
      U_RISSUE: w = '{op: OP_RD_ISSUE,  cond: C_NEXT,      hold: 1'b0, target: U_IDLE};
      U_RCAP:   w = '{op: OP_RD_CAP,    cond: C_ALWAYS,    hold: 1'b0, target: U_EMIT};
      U_EMIT:   w = '{op: OP_EMIT,      cond: C_OUT_FREE,  hold: 1'b1, target: U_IDLE};
      default:  w = '{op: OP_NONE,      cond: C_ALWAYS,    hold: 1'b0, target: U_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of each command's routine.
  function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] cmd);
    logic [UPC_W-1:0] a;
    case (cmd)
      CMD_ADD:  a = U_ADD;
      CMD_TICK: a = U_TICK;
      CMD_TRIG: a = U_TRIG;
      CMD_READ: a = U_RISSUE;
      default:  a = U_IDLE;
    endcase
    return a;
  endfunction

endpackage

>>> hw/rtl/mcft_ram.sv
// ----------------------------------------------------------------------------
// mcft_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mcft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mcft_seq.sv
// ----------------------------------------------------------------------------
// mcft_seq
// Microcode sequencer: step counter, control store and next-step selection.
// ----------------------------------------------------------------------------
module mcft_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            in_command,
  input  mcft_pkg::dp_flags_t   flags,
  output mcft_pkg::seq_ctrl_t   ctrl
);
  import mcft_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic [UPC_W-1:0] tgt;
  uword_t           uw;
  logic             taken;

  assign uw = ucode(upc_r);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (uw.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_ACCEPT:    taken = accept;
      C_ITER_DONE: taken = flags.iter_done;
      C_OUT_FREE:  taken = flags.out_free;
      default:     taken = 1'b0;
    endcase
  end

  // Jump target, fall-through or hold.
  always_comb begin
    tgt = (uw.cond == C_ACCEPT) ? dispatch(in_command) : uw.target;
    if (taken) begin
      upc_nxt = tgt;
    end else if (uw.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl.idle = (upc_r == U_IDLE);
  assign ctrl.op   = uw.op;

endmodule

>>> hw/rtl/mcft_dp.sv
// ----------------------------------------------------------------------------
// mcft_dp
// Datapath of the frame timer: channel tables, tick arithmetic and result
// register, driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module mcft_dp #(
  parameter int CHANNELS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcft_pkg::seq_ctrl_t           ctrl,
  input  logic                          accept,
  input  logic                          in_loop_mode,
  input  logic [mcft_pkg::FRAME_W-1:0]  in_length_frames,
  input  logic [mcft_pkg::RATE_W-1:0]   in_rate,
  input  logic [mcft_pkg::DELTA_W-1:0]  in_delta_time,
  input  logic [mcft_pkg::ID_W-1:0]     in_channel,
  input  logic                          out_stall,
  output mcft_pkg::dp_flags_t           flags,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [mcft_pkg::ID_W-1:0]     out_channel_id,
  output logic [mcft_pkg::CNT_OUT_W-1:0] out_active_count,
  output logic [mcft_pkg::FRAME_W-1:0]  out_frame,
  output logic                          out_running,
  output logic                          out_looping
);
  import mcft_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);
  localparam int XW = (CW > ID_W) ? CW : ID_W;
  localparam int RW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  // Control state.
  logic [CW-1:0]       alloc_r, alloc_nxt;
  logic [CW-1:0]       run_r, run_nxt;
  logic [CW-1:0]       iter_r, iter_nxt;
  logic [CHANNELS-1:0] playing_r, playing_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Latched input word and working registers.
  logic               loop_r;
  logic [FRAME_W-1:0] len_r;
  logic [RATE_W-1:0]  rate_r;
  logic [DELTA_W-1:0] delta_r;
  logic [ID_W-1:0]    chan_r;
  logic [D30_W-1:0]   d30_r;
  logic [PROD_W-1:0]  prod_r;

  // Result being built, and the output register.
  logic [1:0]         res_status_r, res_status_nxt;
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic               res_run_r, res_run_nxt;
  logic               res_loop_r, res_loop_nxt;
  logic [1:0]         out_status_r;
  logic [ID_W-1:0]    out_id_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic               out_run_r;
  logic               out_loop_r;

  // Table ports.
  logic               cfg_we, pos_we, rd_en;
  logic [AW-1:0]      pos_waddr, rd_addr;
  logic [FRAME_W-1:0] pos_wdata;
  logic [CFG_W-1:0]   cfg_wdata, cfg_rdata;
  logic [FRAME_W-1:0] pos_rdata;

  // Index and compare helpers.
  logic [XW-1:0]      alloc_x, chan_x;
  logic [AW-1:0]      alloc_idx, chan_idx, iter_idx;
  logic               full, chan_ok, out_free;
  logic [RW-1:0]      run_x;
  logic [FRAME_W-1:0] len_q;
  logic [RATE_W-1:0]  rate_q;
  logic               loop_q;
  logic [FRAME_W:0]   sum;

  assign alloc_x   = XW'(alloc_r);
  assign chan_x    = XW'(chan_r);
  assign alloc_idx = alloc_x[AW-1:0];
  assign chan_idx  = chan_x[AW-1:0];
  assign iter_idx  = iter_r[AW-1:0];
  assign full      = (alloc_r == CW'(CHANNELS));
  assign chan_ok   = (chan_x < alloc_x);
  assign run_x     = RW'(run_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign len_q  = cfg_rdata[FRAME_W-1:0];
  assign rate_q = cfg_rdata[FRAME_W +: RATE_W];
  assign loop_q = cfg_rdata[CFG_W-1];
  assign sum    = {1'b0, pos_rdata} + (FRAME_W + 1)'(prod_r[PROD_W-1:STEP_LSB]);

  assign flags.iter_done = (iter_r == alloc_r);
  assign flags.out_free  = out_free;

  // Channel set-up word: loop flag, rate and length with defaults applied.
  assign cfg_wdata = {loop_r,
                      (rate_r == '0) ? DEFAULT_RATE : rate_r,
                      (len_r == '0) ? DEFAULT_LENGTH : len_r};

  // The tick loop reads at the iterator, a read command at its channel.
  assign rd_en   = (ctrl.op == OP_CH_READ) || (ctrl.op == OP_RD_ISSUE);
  assign rd_addr = (ctrl.op == OP_CH_READ) ? iter_idx : chan_idx;

  mcft_ram #(.WIDTH(CFG_W), .DEPTH(CHANNELS)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (alloc_idx),
    .wdata (cfg_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cfg_rdata)
  );

  mcft_ram #(.WIDTH(FRAME_W), .DEPTH(CHANNELS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pos_rdata)
  );

  // Operation decode: table writes, flag and count updates, result fields.
  always_comb begin
    alloc_nxt      = alloc_r;
    run_nxt        = run_r;
    iter_nxt       = iter_r;
    playing_nxt    = playing_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_frame_nxt  = res_frame_r;
    res_run_nxt    = res_run_r;
    res_loop_nxt   = res_loop_r;
    cfg_we         = 1'b0;
    pos_we         = 1'b0;
    pos_waddr      = iter_idx;
    pos_wdata      = '0;

    if (accept) begin
      res_status_nxt = ST_OK;
      res_id_nxt     = '0;
      res_frame_nxt  = '0;
      res_run_nxt    = 1'b0;
      res_loop_nxt   = 1'b0;
    end

    case (ctrl.op)
      OP_ADD: begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          cfg_we                 = 1'b1;
          pos_we                 = 1'b1;
          pos_waddr              = alloc_idx;
          playing_nxt[alloc_idx] = loop_r;
          run_nxt                = run_r + CW'(loop_r);
          alloc_nxt              = alloc_r + CW'(1);
          res_id_nxt             = alloc_x[ID_W-1:0];
        end
      end
      OP_TICK_INIT: begin
        iter_nxt = '0;
      end
      OP_UPD: begin
        // Advance a running channel; wrap or stop once it reaches its length.
        if (playing_r[iter_idx]) begin
          pos_we = 1'b1;
          if (sum >= {1'b0, len_q}) begin
            if (!loop_q) begin
              pos_wdata             = len_q;
              playing_nxt[iter_idx] = 1'b0;
              run_nxt               = run_r - CW'(1);
            end
          end else begin
            pos_wdata = sum[FRAME_W-1:0];
          end
        end
        iter_nxt = iter_r + CW'(1);
      end
      OP_TRIG: begin
        res_id_nxt = chan_r;
        if (!chan_ok) begin
          res_status_nxt = ST_NOALLOC;
        end else begin
          pos_we    = 1'b1;
          pos_waddr = chan_idx;
          if (!playing_r[chan_idx]) begin
            run_nxt = run_r + CW'(1);
          end
          playing_nxt[chan_idx] = 1'b1;
        end
      end
      OP_RD_CAP: begin
        res_id_nxt = chan_r;
        if (!chan_ok) begin
          res_status_nxt = ST_NOALLOC;
        end else begin
          res_frame_nxt = pos_rdata;
          res_run_nxt   = playing_r[chan_idx];
          res_loop_nxt  = loop_q;
        end
      end
      default: begin
      end
    endcase
  end

  // The output register is loaded when the result step finds it free.
  always_comb begin
    if ((ctrl.op == OP_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r     <= '0;
      run_r       <= '0;
      iter_r      <= '0;
      playing_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      alloc_r     <= alloc_nxt;
      run_r       <= run_nxt;
      iter_r      <= iter_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      loop_r  <= in_loop_mode;
      len_r   <= in_length_frames;
      rate_r  <= in_rate;
      delta_r <= in_delta_time;
      chan_r  <= in_channel;
    end
    if (ctrl.op == OP_TICK_INIT) begin
      d30_r <= D30_W'(delta_r) * FRAMES_PER_SEC;
    end
    if (ctrl.op == OP_MUL) begin
      prod_r <= PROD_W'(rate_q) * PROD_W'(d30_r);
    end
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_frame_r  <= res_frame_nxt;
    res_run_r    <= res_run_nxt;
    res_loop_r   <= res_loop_nxt;
    if ((ctrl.op == OP_EMIT) && out_free) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_count_r  <= run_x[CNT_OUT_W-1:0];
      out_frame_r  <= res_frame_r;
      out_run_r    <= res_run_r;
      out_loop_r   <= res_loop_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_channel_id   = out_id_r;
  assign out_active_count = out_count_r;
  assign out_frame        = out_frame_r;
  assign out_running      = out_run_r;
  assign out_looping      = out_loop_r;

endmodule

>>> hw/rtl/multi_channel_frame_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_frame_timer
// A bank of frame timers run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage: one command word enters on the in_ channel (add, tick, trigger,
// read) and exactly one result word leaves on the out_ channel, carrying the
// status, the channel id, the running count and, for a read, frame and flags.
// The block takes a word only while its sequencer is idle, so one command is
// worked at a time; it may take the next word while the previous result
// still waits in the output register.
// A tick passes each allocated channel through one table read, one multiply
// and one update step of the shared datapath.
// Reset clears the allocation count, the running flags and the output
// valid flag; the channel tables need no clearing, as the data of
// unallocated entries is never used. If the receiver stalls, the result
// holds in the output register and the sequencer waits in its result step
// until the register is free.
// ----------------------------------------------------------------------------
module multi_channel_frame_timer #(
  parameter int CHANNELS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic                           in_loop_mode,
  input  logic [mcft_pkg::FRAME_W-1:0]   in_length_frames,
  input  logic [mcft_pkg::RATE_W-1:0]    in_rate,
  input  logic [mcft_pkg::DELTA_W-1:0]   in_delta_time,
  input  logic [mcft_pkg::ID_W-1:0]      in_channel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [mcft_pkg::ID_W-1:0]      out_channel_id,
  output logic [mcft_pkg::CNT_OUT_W-1:0] out_active_count,
  output logic [mcft_pkg::FRAME_W-1:0]   out_frame,
  output logic                           out_running,
  output logic                           out_looping
);
  import mcft_pkg::*;

  seq_ctrl_t ctrl;
  dp_flags_t flags;
  logic      accept;

  // A word is taken only while the sequencer waits for a command.
  assign in_stall = !ctrl.idle;
  assign accept   = in_valid && ctrl.idle;

  mcft_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_command (in_command),
    .flags      (flags),
    .ctrl       (ctrl)
  );

  mcft_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .accept           (accept),
    .in_loop_mode     (in_loop_mode),
    .in_length_frames (in_length_frames),
    .in_rate          (in_rate),
    .in_delta_time    (in_delta_time),
    .in_channel       (in_channel),
    .out_stall        (out_stall),
    .flags            (flags),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_channel_id   (out_channel_id),
    .out_active_count (out_active_count),
    .out_frame        (out_frame),
    .out_running      (out_running),
    .out_looping      (out_looping)
  );

endmodule

>>> hw/rtl/mcft_checker.sv
// ----------------------------------------------------------------------------
// mcft_checker
// Port-level checks of the frame timer, bound to the top level.
// ----------------------------------------------------------------------------
module mcft_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [1:0]                     out_status,
  input logic [mcft_pkg::ID_W-1:0]      out_channel_id,
  input logic [mcft_pkg::FRAME_W-1:0]   out_frame,
  input logic                           out_running,
  input logic                           out_looping
);
  import mcft_pkg::*;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word withdrawn while stalled");

  // Once a word is taken, the block is busy with it in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new word taken while a command was in progress");

  // A full table reports channel id zero.
  a_full_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_channel_id == '0))
    else $error("full status with non-zero channel id");

  // A channel that is not allocated reports no frame and no flags.
  a_noalloc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOALLOC) |->
      (out_frame == '0) && !out_running && !out_looping)
    else $error("unallocated channel reported frame or flags");

endmodule

bind multi_channel_frame_timer mcft_checker u_mcft_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_channel_id (out_channel_id),
  .out_frame      (out_frame),
  .out_running    (out_running),
  .out_looping    (out_looping)
);
